// ===== rtl/sseq_pkg.sv =====
// Package with shared constants, a type and a helper function of the shelving equalizer.
package sseq_pkg;

  localparam int NUM_POINTS_DEF   = 15;
  localparam int MAX_SECTIONS_DEF = 6;
  localparam logic signed [31:0] UNITY_GAIN = 32'sd1048576;

  // Coefficient kinds carried by a write word.
  localparam logic [2:0] KIND_C1    = 3'd0;
  localparam logic [2:0] KIND_C2    = 3'd1;
  localparam logic [2:0] KIND_D0    = 3'd2;
  localparam logic [2:0] KIND_D1    = 3'd3;
  localparam logic [2:0] KIND_GAIN  = 3'd4;
  localparam logic [2:0] KIND_COUNT = 3'd5;

  // Operation codes of an input word.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic use_acc;
  } mac_ctl_t;

  // Saturate a 34-bit sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) sat32 = 32'sh7FFF_FFFF;
    else if (v < lo) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

// ===== rtl/sseq_mac.sv =====
// Shared multiply unit: one Q12.20 by Q.23 product, rounded, plus a running sum.
module sseq_mac (
  input  logic                clk,
  input  logic                start,
  input  sseq_pkg::mac_ctl_t  ctl,
  input  logic signed [31:0]  coef,
  input  logic signed [31:0]  data,
  input  logic signed [33:0]  addend,
  output logic signed [33:0]  acc
);

  logic signed [63:0] prod_r;
  logic signed [63:0] prod_nxt;
  logic               add_r;
  logic signed [47:0] base_r;
  logic signed [47:0] acc_r;
  logic signed [44:0] rnd;
  logic signed [47:0] sum;

  // Product stage, registered before the rounding add.
  assign prod_nxt = coef * data;

  // A chained step takes the sum that is being formed in the same cycle.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    add_r  <= start;
    base_r <= ctl.use_acc ? (add_r ? sum : acc_r) : 48'(addend);
  end

  // Round to Q.23 and accumulate exactly; two products and a state value fit in 48 bits.
  assign rnd = 45'((prod_r + 64'sd524288) >>> 20);
  assign sum = base_r + 48'(rnd);

  always_ff @(posedge clk) begin
    if (add_r) acc_r <= sum;
  end

  // Clamp to 34 bits, which keeps the later 32-bit saturation unchanged.
  assign acc = (acc_r > 48'sh1_FFFF_FFFF) ? 34'sh1_FFFF_FFFF :
               (acc_r < -48'sh2_0000_0000) ? -34'sh2_0000_0000 : acc_r[33:0];

endmodule

// ===== rtl/stereo_svf_shelf_eq_cascade.sv =====
// Top level of the stereo cascaded state-variable shelving equalizer.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall | operation, samples, coefficient write
//  out_    | output    | out_valid/out_stall | left/right result, block end
//
// A coefficient write is taken in an idle cycle. A sample is taken in an idle cycle
// and its result is ready once both channels have passed every band and the section
// counts of all bands: every product goes through the single multiply unit, whose
// start is registered in add_r before its sum is registered in acc_r.
// Reset clears all integrators with a clearing pass, during which no word is taken.
// A result waits in the output register; a new word is taken while it waits
// only when it is a write; a sample waits until the result is taken.
module stereo_svf_shelf_eq_cascade #(
  parameter int NUM_POINTS   = sseq_pkg::NUM_POINTS_DEF,
  parameter int MAX_SECTIONS = sseq_pkg::MAX_SECTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [23:0] in_left_sample,
  input  logic signed [23:0] in_right_sample,
  input  logic               in_end_of_block,
  input  logic [3:0]         in_coef_band,
  input  logic [2:0]         in_coef_section,
  input  logic [2:0]         in_coef_kind,
  input  logic signed [31:0] in_coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_left_out,
  output logic signed [23:0] out_right_out,
  output logic               out_block_end_out
);

  localparam int NB  = NUM_POINTS - 1;
  localparam int NS  = NB * MAX_SECTIONS;
  localparam int SW  = $clog2(NS);
  localparam int BW  = $clog2(NB);
  localparam int CW  = $clog2(MAX_SECTIONS + 1);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_BAND  = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_Y     = 4'd4;
  localparam logic [3:0] ST_O1    = 4'd5;
  localparam logic [3:0] ST_O2    = 4'd6;
  localparam logic [3:0] ST_Z2    = 4'd7;
  localparam logic [3:0] ST_Z1    = 4'd8;
  localparam logic [3:0] ST_G     = 4'd9;
  localparam logic [3:0] ST_WAIT  = 4'd10;
  localparam logic [3:0] ST_NEXT  = 4'd11;

  // Coefficient and state memories.
  logic signed [31:0] c1_mem [NS];
  logic signed [31:0] c2_mem [NS];
  logic signed [31:0] d0_mem [NS];
  logic signed [31:0] d1_mem [NS];
  logic signed [31:0] z1_mem [2*NS];
  logic signed [31:0] z2_mem [2*NS];
  logic signed [31:0] gain_r [NB];
  logic [CW-1:0]      cnt_r  [NB];

  logic [3:0]         st_r;
  logic [SW:0]        clr_r;
  logic [BW-1:0]      band_r;
  logic [CW-1:0]      sec_r;
  logic               ch_r;
  logic [1:0]         wt_r;
  logic [3:0]         ret_r;
  logic signed [31:0] x_r, y_r, a1_r, a2_r;
  logic signed [31:0] c1_q, c2_q, d0_q, d1_q, z1_q, z2_q;
  logic signed [23:0] rs_r;
  logic               eob_r;
  logic               ov_r;
  logic signed [23:0] ol_r, or_r;
  logic               oe_r;

  logic [SW-1:0]      slot;
  logic [SW-1:0]      wslot;
  logic [SW:0]        zaddr;
  logic               take;
  logic               mstart;
  sseq_pkg::mac_ctl_t mctl;
  logic signed [31:0] mcoef, mdata;
  logic signed [33:0] madd, macc;
  logic signed [31:0] msat;
  logic signed [31:0] cnt_val;
  logic signed [23:0] x24;

  assign slot  = SW'(band_r * MAX_SECTIONS) + SW'(sec_r);
  assign wslot = SW'(32'(in_coef_band) * MAX_SECTIONS) + SW'(in_coef_section);
  assign zaddr = ch_r ? (SW+1)'(slot) + (SW+1)'(NS) : (SW+1)'(slot);
  assign msat  = sseq_pkg::sat32(macc);

  // A sample is taken only when the output register is free.
  assign in_stall = !((st_r == ST_IDLE) && (in_operation == sseq_pkg::OP_WRITE || !ov_r));
  assign take     = in_valid && !in_stall;

  // Memory reads for the current slot, registered.
  always_ff @(posedge clk) begin
    c1_q <= c1_mem[slot];
    c2_q <= c2_mem[slot];
    d0_q <= d0_mem[slot];
    d1_q <= d1_mem[slot];
    z1_q <= z1_mem[zaddr];
    z2_q <= z2_mem[zaddr];
  end

  // Coefficient writes.
  always_ff @(posedge clk) begin
    if (take && in_operation == sseq_pkg::OP_WRITE && 32'(in_coef_band) < NB &&
        32'(in_coef_section) < MAX_SECTIONS) begin
      unique case (in_coef_kind)
        sseq_pkg::KIND_C1: c1_mem[wslot] <= in_coef_value;
        sseq_pkg::KIND_C2: c2_mem[wslot] <= in_coef_value;
        sseq_pkg::KIND_D0: d0_mem[wslot] <= in_coef_value;
        sseq_pkg::KIND_D1: d1_mem[wslot] <= in_coef_value;
        default: ;
      endcase
    end
  end

  // Section count saturation.
  always_comb begin
    cnt_val = in_coef_value;
    if (in_coef_value < 0) cnt_val = '0;
    else if (in_coef_value > MAX_SECTIONS) cnt_val = MAX_SECTIONS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NB; b++) begin
        gain_r[b] <= sseq_pkg::UNITY_GAIN;
        cnt_r[b]  <= '0;
      end
    end else if (take && in_operation == sseq_pkg::OP_WRITE && 32'(in_coef_band) < NB) begin
      if (in_coef_kind == sseq_pkg::KIND_GAIN) gain_r[in_coef_band[BW-1:0]] <= in_coef_value;
      if (in_coef_kind == sseq_pkg::KIND_COUNT) cnt_r[in_coef_band[BW-1:0]] <= CW'(cnt_val);
    end
  end

  // Integrator writes and clearing pass; the new first integrator comes straight
  // from the multiply unit.
  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR) begin
      z1_mem[clr_r] <= '0;
      z2_mem[clr_r] <= '0;
    end else if (st_r == ST_NEXT) begin
      z1_mem[zaddr] <= msat;
      z2_mem[zaddr] <= a2_r;
    end
  end

  // Multiply unit control.
  always_comb begin
    mstart = 1'b0;
    mctl   = '0;
    mcoef  = d0_q;
    mdata  = y_r;
    madd   = '0;
    unique case (st_r)
      ST_O1: begin mstart = 1'b1; mcoef = d0_q; mdata = y_r; madd = 34'(a2_r); end
      ST_O2: begin mstart = 1'b1; mctl.use_acc = 1'b1; mcoef = d1_q; mdata = a1_r; end
      ST_Z2: begin mstart = 1'b1; mcoef = c2_q; mdata = a1_r; madd = 34'(a2_r); end
      ST_Z1: begin mstart = 1'b1; mcoef = c1_q; mdata = y_r; madd = 34'(a1_r); end
      ST_G:  begin mstart = 1'b1; mcoef = gain_r[band_r]; mdata = x_r; end
      default: ;
    endcase
  end

  sseq_mac u_mac (
    .clk    (clk),
    .start  (mstart),
    .ctl    (mctl),
    .coef   (mcoef),
    .data   (mdata),
    .addend (madd),
    .acc    (macc)
  );

  // Final value saturated to the 24-bit output range.
  assign x24 = (msat > 32'sd8388607) ? 24'sh7FFFFF :
               (msat < -32'sd8388608) ? 24'sh800000 : msat[23:0];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
      wt_r  <= '0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (SW+1)'(2*NS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: if (take && in_operation == sseq_pkg::OP_SAMPLE) begin
          rs_r <= in_right_sample; eob_r <= in_end_of_block;
          x_r  <= 32'(in_left_sample);
          ch_r <= 1'b0; band_r <= '0; sec_r <= '0;
          st_r <= ST_BAND;
        end
        ST_BAND: st_r <= (sec_r < cnt_r[band_r]) ? ST_RD : ST_G;
        ST_RD: begin wt_r <= 2'd1; ret_r <= ST_Y; st_r <= ST_WAIT; end
        ST_Y: begin
          a1_r <= z1_q; a2_r <= z2_q;
          y_r  <= sseq_pkg::sat32(34'(x_r) - 34'(z1_q) - 34'(z2_q));
          st_r <= ST_O1;
        end
        ST_O1: st_r <= ST_O2;
        ST_O2: begin wt_r <= 2'd2; ret_r <= ST_Z2; st_r <= ST_WAIT; end
        ST_Z2: begin x_r <= msat; wt_r <= 2'd2; ret_r <= ST_Z1; st_r <= ST_WAIT; end
        ST_Z1: begin a2_r <= msat; wt_r <= 2'd2; ret_r <= ST_NEXT; st_r <= ST_WAIT; end
        ST_NEXT: begin
          a1_r  <= msat;
          sec_r <= sec_r + 1'b1;
          st_r  <= ST_BAND;
        end
        ST_G: begin wt_r <= 2'd2; ret_r <= ST_IDLE; st_r <= ST_WAIT; sec_r <= '0; end
        ST_WAIT: begin
          wt_r <= wt_r - 1'b1;
          if (wt_r == 2'd1) begin
            if (ret_r != ST_IDLE) begin
              st_r <= ret_r;
            end else if (32'(band_r) != NB - 1) begin
              // End of a band: the gained value feeds the next band.
              x_r    <= msat;
              band_r <= band_r + 1'b1;
              st_r   <= ST_BAND;
            end else if (!ch_r) begin
              // Left channel done, start the right one.
              ol_r   <= x24;
              ch_r   <= 1'b1;
              band_r <= '0;
              x_r    <= 32'(rs_r);
              st_r   <= ST_BAND;
            end else begin
              or_r <= x24;
              oe_r <= eob_r;
              ov_r <= 1'b1;
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_left_out      = ol_r;
  assign out_right_out     = or_r;
  assign out_block_end_out = oe_r;

  // The multiply unit is only started while a sample is in work.
  assert property (@(posedge clk) disable iff (!rst_n)
    mstart |-> (st_r != ST_IDLE && st_r != ST_CLEAR)) else $error("mac start while idle");
  // No word is taken during the clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> in_stall) else $error("word taken while clearing");
  // A new result never overwrites one that waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
  // The section counter never passes the configured count of its band.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BAND) |-> (sec_r <= cnt_r[band_r])) else $error("section overrun");

endmodule
